>>> hw/rtl/mk2ps2_pkg.sv
// ----------------------------------------------------------------------------
// mk2ps2_pkg
// Types, scan code tables and byte constants for the matrix key to PS/2
// scan code set 2 encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mk2ps2_pkg;

  typedef struct packed {
    logic [3:0] column;
    logic [7:0] row_levels;
    logic       ms_tick;
  } in_payload_t;

  typedef struct packed {
    logic [7:0] ps2_byte;
    logic       last_byte;
  } out_payload_t;

  typedef struct packed {
    logic [9:0] typematic_delay_ms;
    logic [8:0] typematic_repeat_ms;
    logic [7:0] debounce_ms;
  } cfg_regs_t;

  // configuration register indexes
  localparam logic [1:0] REG_TYPEMATIC_DELAY  = 2'd0;
  localparam logic [1:0] REG_TYPEMATIC_REPEAT = 2'd1;
  localparam logic [1:0] REG_DEBOUNCE         = 2'd2;

  localparam logic [9:0] DELAY_RESET    = 10'd500;
  localparam logic [8:0] REPEAT_RESET   = 9'd54;
  localparam logic [7:0] DEBOUNCE_RESET = 8'd2;

  typedef enum logic [1:0] {
    CMD_MAKE_MODS,
    CMD_MAKE,
    CMD_BREAK
  } cmd_kind_t;

  // modifier bits
  localparam int MOD_CTRL   = 0;
  localparam int MOD_LSHIFT = 1;
  localparam int MOD_RSHIFT = 2;

  // code flag bits
  localparam int FLAG_E0    = 8;
  localparam int FLAG_SHIFT = 9;
  localparam int FLAG_ALTGR = 10;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [10:0] code;
    logic [2:0]  mods;
  } cmd_t;

  localparam int CMDQ_DEPTH = 4;
  localparam int SLOTS      = 12;

  localparam logic [7:0]  NO_KEY     = 8'hff;
  localparam logic [10:0] SAT_MAX    = 11'd2047;
  localparam logic [3:0]  CTRL_COL   = 4'd8;
  localparam logic [3:0]  SHIFT_COL  = 4'd6;
  localparam int          LSHIFT_ROW = 0;
  localparam int          RSHIFT_ROW = 6;
  localparam int          CTRL_ROW   = 0;

  localparam logic [7:0] BYTE_E0     = 8'he0;
  localparam logic [7:0] BYTE_F0     = 8'hf0;
  localparam logic [7:0] BYTE_CTRL   = 8'h14;
  localparam logic [7:0] BYTE_RIGHT  = 8'h11;
  localparam logic [7:0] BYTE_SHIFT  = 8'h12;

  localparam int TABLE_LEN = 80;

  localparam logic [10:0] CODE_TAB0 [TABLE_LEN] = '{
    11'h01e, 11'h02e, 11'h03e, 11'h055, 11'h00a, 11'h16c, 11'h000, 11'h000,
    11'h016, 11'h025, 11'h03d, 11'h045, 11'h083, 11'h17a, 11'h000, 11'h001,
    11'h076, 11'h01b, 11'h02b, 11'h033, 11'h05d, 11'h042, 11'h04c, 11'h003,
    11'h01c, 11'h023, 11'h034, 11'h03b, 11'h05a, 11'h04b, 11'h052, 11'h00b,
    11'h00d, 11'h01d, 11'h02d, 11'h035, 11'h05b, 11'h043, 11'h04d, 11'h446,
    11'h015, 11'h024, 11'h02c, 11'h03c, 11'h43e, 11'h044, 11'h054, 11'h00c,
    11'h000, 11'h021, 11'h032, 11'h049, 11'h461, 11'h000, 11'h000, 11'h004,
    11'h01a, 11'h02a, 11'h031, 11'h041, 11'h415, 11'h000, 11'h172, 11'h006,
    11'h000, 11'h022, 11'h029, 11'h03a, 11'h174, 11'h000, 11'h04a, 11'h005,
    11'h061, 11'h026, 11'h036, 11'h046, 11'h066, 11'h04e, 11'h000, 11'h000
  };

  localparam logic [10:0] CODE_TAB1 [TABLE_LEN] = '{
    11'h21e, 11'h22e, 11'h23e, 11'h255, 11'h20a, 11'h169, 11'h000, 11'h000,
    11'h216, 11'h225, 11'h23d, 11'h245, 11'h283, 11'h17d, 11'h000, 11'h201,
    11'h276, 11'h21b, 11'h22b, 11'h233, 11'h25d, 11'h242, 11'h24c, 11'h203,
    11'h21c, 11'h223, 11'h234, 11'h23b, 11'h05a, 11'h24b, 11'h252, 11'h20b,
    11'h00d, 11'h21d, 11'h22d, 11'h235, 11'h25b, 11'h243, 11'h24d, 11'h44e,
    11'h215, 11'h224, 11'h22c, 11'h23c, 11'h00e, 11'h244, 11'h254, 11'h20c,
    11'h000, 11'h221, 11'h232, 11'h249, 11'h45b, 11'h000, 11'h000, 11'h204,
    11'h21a, 11'h22a, 11'h231, 11'h241, 11'h000, 11'h000, 11'h175, 11'h206,
    11'h000, 11'h222, 11'h000, 11'h23a, 11'h16b, 11'h000, 11'h24a, 11'h205,
    11'h261, 11'h226, 11'h236, 11'h246, 11'h171, 11'h24e, 11'h000, 11'h000
  };

  // key numbers past the tables have no code
  function automatic logic [10:0] key_code(input logic [7:0] key, input logic lshift);
    logic [10:0] c;
    c = 11'd0;
    if (key < 8'(TABLE_LEN)) begin
      c = lshift ? CODE_TAB1[key[6:0]] : CODE_TAB0[key[6:0]];
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/matrix_key_to_ps2_encoder.sv
// ----------------------------------------------------------------------------
// matrix_key_to_ps2_encoder
// Key matrix column samples in, PS/2 scan code set 2 bytes out.
// ----------------------------------------------------------------------------
// One column sample is taken per clock while full is low. The front end does
// the whole pass and key logic for a sample in that cycle; a sample that ends
// a pass and has bytes to send leaves one command in a four-deep command
// queue, and full rises only when that queue is full. The byte sequencer
// drains one command at a time and puts one byte per clock into the output
// register while it is empty or popped (up to 12 bytes per command); a queue
// entry frees as its command loads. Configuration writes are always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_key_to_ps2_encoder #(
  parameter int COLUMNS = 10
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  mk2ps2_pkg::in_payload_t   in_data,
  input  wire                       push,
  output logic                      full,
  output mk2ps2_pkg::out_payload_t  out_data,
  output logic                      empty,
  input  wire                       pop,
  input  wire                       cfg_valid,
  output logic                      cfg_ready,
  input  wire [1:0]                 cfg_index,
  input  wire [9:0]                 cfg_data
);

  mk2ps2_pkg::cfg_regs_t cfg_r, cfg_nxt;
  mk2ps2_pkg::cmd_t      front_cmd;
  mk2ps2_pkg::cmd_t      q_cmd;
  logic                  front_cmd_valid;
  logic                  q_full, q_empty, q_pop;
  logic                  in_accept;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign in_accept = push && !q_full;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        mk2ps2_pkg::REG_TYPEMATIC_DELAY:  cfg_nxt.typematic_delay_ms  = cfg_data;
        mk2ps2_pkg::REG_TYPEMATIC_REPEAT: cfg_nxt.typematic_repeat_ms = cfg_data[8:0];
        mk2ps2_pkg::REG_DEBOUNCE:         cfg_nxt.debounce_ms         = cfg_data[7:0];
        default:                          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.typematic_delay_ms  <= mk2ps2_pkg::DELAY_RESET;
      cfg_r.typematic_repeat_ms <= mk2ps2_pkg::REPEAT_RESET;
      cfg_r.debounce_ms         <= mk2ps2_pkg::DEBOUNCE_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mk2ps2_front #(
    .COLUMNS (COLUMNS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_accept),
    .item       (in_data),
    .cfg        (cfg_r),
    .cmd_valid  (front_cmd_valid),
    .cmd        (front_cmd)
  );

  mk2ps2_cmdq u_cmdq (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (front_cmd_valid),
    .wr_cmd (front_cmd),
    .full   (q_full),
    .rd_en  (q_pop),
    .rd_cmd (q_cmd),
    .empty  (q_empty)
  );

  mk2ps2_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_cmd    (q_cmd),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

>>> hw/rtl/mk2ps2_front.sv
// ----------------------------------------------------------------------------
// mk2ps2_front
// Takes column samples, tracks the scan pass, debounce and typematic timing,
// and issues one byte-run command per pass when a code has to be sent.
// ----------------------------------------------------------------------------
`default_nettype none

module mk2ps2_front #(
  parameter int COLUMNS = 10
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      item_valid,
  input  mk2ps2_pkg::in_payload_t  item,
  input  mk2ps2_pkg::cfg_regs_t    cfg,
  output logic                     cmd_valid,
  output mk2ps2_pkg::cmd_t         cmd
);

  localparam logic [4:0] COLS     = 5'(COLUMNS);
  localparam logic [3:0] LAST_COL = 4'(COLUMNS - 1);

  logic [7:0]  scan_key_r, scan_key_nxt;
  logic [2:0]  scan_mods_r, scan_mods_nxt;
  logic [2:0]  held_mods_r, held_mods_nxt;
  logic [7:0]  cand_key_r, cand_key_nxt;
  logic [7:0]  pressed_key_r, pressed_key_nxt;
  logic [10:0] deb_elapsed_r, deb_elapsed_nxt;
  logic [10:0] rep_elapsed_r, rep_elapsed_nxt;
  logic        repeating_r, repeating_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_key_r    <= mk2ps2_pkg::NO_KEY;
      scan_mods_r   <= 3'd0;
      held_mods_r   <= 3'd0;
      cand_key_r    <= mk2ps2_pkg::NO_KEY;
      pressed_key_r <= mk2ps2_pkg::NO_KEY;
      deb_elapsed_r <= 11'd0;
      rep_elapsed_r <= 11'd0;
      repeating_r   <= 1'b0;
    end else begin
      scan_key_r    <= scan_key_nxt;
      scan_mods_r   <= scan_mods_nxt;
      held_mods_r   <= held_mods_nxt;
      cand_key_r    <= cand_key_nxt;
      pressed_key_r <= pressed_key_nxt;
      deb_elapsed_r <= deb_elapsed_nxt;
      rep_elapsed_r <= rep_elapsed_nxt;
      repeating_r   <= repeating_nxt;
    end
  end

  always_comb begin
    logic [7:0]  nomods;
    logic [2:0]  first_row;
    logic [7:0]  idx;
    logic        lshift;
    logic [10:0] code;
    logic [10:0] limit;
    logic        emit;

    scan_key_nxt    = scan_key_r;
    scan_mods_nxt   = scan_mods_r;
    held_mods_nxt   = held_mods_r;
    cand_key_nxt    = cand_key_r;
    pressed_key_nxt = pressed_key_r;
    deb_elapsed_nxt = deb_elapsed_r;
    rep_elapsed_nxt = rep_elapsed_r;
    repeating_nxt   = repeating_r;
    nomods          = item.row_levels;
    first_row       = 3'd0;
    idx             = pressed_key_r;
    lshift          = held_mods_r[mk2ps2_pkg::MOD_LSHIFT];
    code            = 11'd0;
    limit           = 11'd0;
    emit            = 1'b0;
    cmd.kind        = mk2ps2_pkg::CMD_MAKE;
    cmd.mods        = held_mods_r;

    if (item_valid) begin
      if (item.ms_tick) begin
        if (deb_elapsed_r != mk2ps2_pkg::SAT_MAX) deb_elapsed_nxt = deb_elapsed_r + 11'd1;
        if (rep_elapsed_r != mk2ps2_pkg::SAT_MAX) rep_elapsed_nxt = rep_elapsed_r + 11'd1;
      end
      if ({1'b0, item.column} < COLS) begin
        if (item.column == 4'd0) begin
          scan_key_nxt  = mk2ps2_pkg::NO_KEY;
          scan_mods_nxt = 3'd0;
        end
        if (item.column == mk2ps2_pkg::CTRL_COL) begin
          nomods[mk2ps2_pkg::CTRL_ROW] = 1'b1;
          if (!item.row_levels[mk2ps2_pkg::CTRL_ROW]) scan_mods_nxt[mk2ps2_pkg::MOD_CTRL] = 1'b1;
        end
        if (item.column == mk2ps2_pkg::SHIFT_COL) begin
          nomods[mk2ps2_pkg::LSHIFT_ROW] = 1'b1;
          nomods[mk2ps2_pkg::RSHIFT_ROW] = 1'b1;
          if (!item.row_levels[mk2ps2_pkg::LSHIFT_ROW]) begin
            scan_mods_nxt[mk2ps2_pkg::MOD_LSHIFT] = 1'b1;
          end
          if (!item.row_levels[mk2ps2_pkg::RSHIFT_ROW]) begin
            scan_mods_nxt[mk2ps2_pkg::MOD_RSHIFT] = 1'b1;
          end
        end
        for (int i = 7; i >= 0; i--) begin
          if (!nomods[i]) first_row = 3'(i);
        end
        if (scan_key_nxt == mk2ps2_pkg::NO_KEY && nomods != 8'hff) begin
          scan_key_nxt = {1'b0, item.column, first_row};
        end

        // end of pass: key logic
        if (item.column == LAST_COL) begin
          if (pressed_key_r == mk2ps2_pkg::NO_KEY) begin
            idx    = scan_key_nxt;
            lshift = scan_mods_nxt[mk2ps2_pkg::MOD_LSHIFT];
          end
          code = mk2ps2_pkg::key_code(idx, lshift);
          if (pressed_key_r == mk2ps2_pkg::NO_KEY) begin
            if (cand_key_r == mk2ps2_pkg::NO_KEY) begin
              cand_key_nxt  = scan_key_nxt;
              held_mods_nxt = scan_mods_nxt;
              if (scan_key_nxt != mk2ps2_pkg::NO_KEY) deb_elapsed_nxt = 11'd0;
            end else if (deb_elapsed_nxt > {3'd0, cfg.debounce_ms}) begin
              held_mods_nxt = scan_mods_nxt;
              if (scan_key_nxt == cand_key_r) begin
                pressed_key_nxt = scan_key_nxt;
                rep_elapsed_nxt = 11'd0;
                repeating_nxt   = 1'b0;
                emit            = 1'b1;
                cmd.kind        = mk2ps2_pkg::CMD_MAKE_MODS;
                cmd.mods        = scan_mods_nxt;
              end
              cand_key_nxt = mk2ps2_pkg::NO_KEY;
            end
          end else if (scan_key_nxt == mk2ps2_pkg::NO_KEY) begin
            pressed_key_nxt = mk2ps2_pkg::NO_KEY;
            emit            = 1'b1;
            cmd.kind        = mk2ps2_pkg::CMD_BREAK;
          end else begin
            limit = repeating_r ? {2'd0, cfg.typematic_repeat_ms}
                                : {1'b0, cfg.typematic_delay_ms};
            if (rep_elapsed_nxt > limit) begin
              rep_elapsed_nxt = 11'd0;
              repeating_nxt   = 1'b1;
              emit            = 1'b1;
              cmd.kind        = mk2ps2_pkg::CMD_MAKE;
            end
          end
        end
      end
    end

    cmd.code  = code;
    // a zero code is tracked but sends nothing
    cmd_valid = emit && (code != 11'd0);
  end

  a_no_cand_while_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    (pressed_key_r != mk2ps2_pkg::NO_KEY) |-> (cand_key_r == mk2ps2_pkg::NO_KEY))
    else $error("candidate held while a key is pressed");

  a_cmd_on_last_col: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_valid |-> (item_valid && item.column == LAST_COL))
    else $error("command issued outside end of pass");

endmodule

`default_nettype wire

>>> hw/rtl/mk2ps2_cmdq.sv
// ----------------------------------------------------------------------------
// mk2ps2_cmdq
// Small command queue between the scan front end and the byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module mk2ps2_cmdq (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                wr_en,
  input  mk2ps2_pkg::cmd_t   wr_cmd,
  output logic               full,
  input  wire                rd_en,
  output mk2ps2_pkg::cmd_t   rd_cmd,
  output logic               empty
);

  localparam int PW = $clog2(mk2ps2_pkg::CMDQ_DEPTH);
  localparam logic [PW:0] DEPTH_CNT = (PW + 1)'(mk2ps2_pkg::CMDQ_DEPTH);

  mk2ps2_pkg::cmd_t entry_r [mk2ps2_pkg::CMDQ_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   count_r, count_nxt;
  logic          do_wr, do_rd;

  assign full   = (count_r == DEPTH_CNT);
  assign empty  = (count_r == '0);
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_cmd = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr && !do_rd) count_nxt = count_r + 1'b1;
    else if (do_rd && !do_wr) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) entry_r[wr_ptr_r] <= wr_cmd;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_CNT)
    else $error("command queue overfilled");

endmodule

`default_nettype wire

>>> hw/rtl/mk2ps2_back.sv
// ----------------------------------------------------------------------------
// mk2ps2_back
// Byte sequencer: expands one command into its prefix, code and break bytes
// and feeds the output register, one byte per cycle while it is free or read.
// ----------------------------------------------------------------------------
`default_nettype none

module mk2ps2_back (
  input  wire                       clk,
  input  wire                       rst_n,
  input  mk2ps2_pkg::cmd_t          q_cmd,
  input  wire                       q_empty,
  output logic                      q_pop,
  output logic                      empty,
  input  wire                       pop,
  output mk2ps2_pkg::out_payload_t  out_data
);

  localparam int SW = $clog2(mk2ps2_pkg::SLOTS);

  // enabled byte slots of a command, lowest slot goes first
  function automatic logic [mk2ps2_pkg::SLOTS-1:0] slot_mask(input mk2ps2_pkg::cmd_t c);
    logic [mk2ps2_pkg::SLOTS-1:0] m;
    logic wm, e0, sh, ag, rs, ct;
    m  = '0;
    wm = (c.kind == mk2ps2_pkg::CMD_MAKE_MODS);
    e0 = c.code[mk2ps2_pkg::FLAG_E0];
    sh = c.code[mk2ps2_pkg::FLAG_SHIFT];
    ag = c.code[mk2ps2_pkg::FLAG_ALTGR];
    rs = c.mods[mk2ps2_pkg::MOD_RSHIFT];
    ct = c.mods[mk2ps2_pkg::MOD_CTRL];
    case (c.kind)
      mk2ps2_pkg::CMD_MAKE_MODS, mk2ps2_pkg::CMD_MAKE: begin
        m[0] = wm & ct;
        m[1] = wm & rs;
        m[2] = wm & sh;
        m[3] = wm & ag;
        m[4] = wm & ag;
        m[5] = e0;
        m[6] = 1'b1;
      end
      mk2ps2_pkg::CMD_BREAK: begin
        m[0]  = e0;
        m[1]  = 1'b1;
        m[2]  = 1'b1;
        m[3]  = ag;
        m[4]  = ag;
        m[5]  = ag;
        m[6]  = sh;
        m[7]  = sh;
        m[8]  = rs;
        m[9]  = rs;
        m[10] = ct;
        m[11] = ct;
      end
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [7:0] slot_byte(input mk2ps2_pkg::cmd_t c, input logic [SW-1:0] s);
    logic [7:0] b;
    b = 8'd0;
    if (c.kind == mk2ps2_pkg::CMD_BREAK) begin
      case (s)
        4'd0:    b = mk2ps2_pkg::BYTE_E0;
        4'd1:    b = mk2ps2_pkg::BYTE_F0;
        4'd2:    b = c.code[7:0];
        4'd3:    b = mk2ps2_pkg::BYTE_E0;
        4'd4:    b = mk2ps2_pkg::BYTE_F0;
        4'd5:    b = mk2ps2_pkg::BYTE_RIGHT;
        4'd6:    b = mk2ps2_pkg::BYTE_F0;
        4'd7:    b = mk2ps2_pkg::BYTE_SHIFT;
        4'd8:    b = mk2ps2_pkg::BYTE_F0;
        4'd9:    b = mk2ps2_pkg::BYTE_RIGHT;
        4'd10:   b = mk2ps2_pkg::BYTE_F0;
        4'd11:   b = mk2ps2_pkg::BYTE_CTRL;
        default: b = 8'd0;
      endcase
    end else begin
      case (s)
        4'd0:    b = mk2ps2_pkg::BYTE_CTRL;
        4'd1:    b = mk2ps2_pkg::BYTE_RIGHT;
        4'd2:    b = mk2ps2_pkg::BYTE_SHIFT;
        4'd3:    b = mk2ps2_pkg::BYTE_E0;
        4'd4:    b = mk2ps2_pkg::BYTE_RIGHT;
        4'd5:    b = mk2ps2_pkg::BYTE_E0;
        4'd6:    b = c.code[7:0];
        default: b = 8'd0;
      endcase
    end
    return b;
  endfunction

  mk2ps2_pkg::cmd_t              cmd_r, cmd_nxt;
  logic [mk2ps2_pkg::SLOTS-1:0]  mask_r, mask_nxt;
  logic                          out_valid_r, out_valid_nxt;
  mk2ps2_pkg::out_payload_t      out_data_r, out_data_nxt;
  logic [mk2ps2_pkg::SLOTS-1:0]  rest;
  logic [SW-1:0]                 slot;
  logic                          adv;
  logic                          load;

  always_comb begin
    slot = '0;
    for (int i = mk2ps2_pkg::SLOTS - 1; i >= 0; i--) begin
      if (mask_r[i]) slot = SW'(i);
    end
    rest = mask_r & (mask_r - 1'b1);
    adv  = (mask_r != '0) && (!out_valid_r || pop);
    // next command may load as the current one hands over its last byte
    load = !q_empty && ((mask_r == '0) || (adv && rest == '0));

    cmd_nxt       = load ? q_cmd : cmd_r;
    mask_nxt      = load ? slot_mask(q_cmd) : (adv ? rest : mask_r);
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !pop;
    if (adv) begin
      out_data_nxt.ps2_byte  = slot_byte(cmd_r, slot);
      out_data_nxt.last_byte = (rest == '0);
      out_valid_nxt          = 1'b1;
    end
  end

  assign q_pop    = load;
  assign empty    = !out_valid_r;
  assign out_data = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    out_data_r <= out_data_nxt;
  end

  a_more_after_nonlast: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.last_byte) |-> (mask_r != '0))
    else $error("run ended without a final byte");

  a_load_fills_mask: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (mask_r != '0))
    else $error("loaded command has no bytes");

endmodule

`default_nettype wire

>>> tb/sv/matrix_key_to_ps2_encoder_tb.sv
// ----------------------------------------------------------------------------
// matrix_key_to_ps2_encoder_tb
// Self-checking bench for the key matrix to PS/2 set 2 encoder. Column samples
// are pushed through the input queue port; a local scan/debounce/typematic
// predictor builds the expected byte runs, and every popped byte is compared
// against the oldest one. Directed key strokes cover defaults, modifier and
// AltGr wraps, zero codes, odd column orders and counter limits, followed by
// random typing with random stalls on both ports.
// ----------------------------------------------------------------------------
module matrix_key_to_ps2_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mk2ps2_pkg::in_payload_t;
  import mk2ps2_pkg::out_payload_t;

  localparam int          NCOLS         = 10;
  localparam int          TABLE_SIZE    = 80;
  localparam logic [7:0]  KEY_NONE      = 8'hff;
  localparam logic [10:0] COUNT_MAX     = 11'd2047;
  localparam int          HAS_E0        = 8;
  localparam int          HAS_SHIFT     = 9;
  localparam int          HAS_ALTGR     = 10;
  localparam int          M_CTRL        = 0;
  localparam int          M_LSHIFT      = 1;
  localparam int          M_RSHIFT      = 2;
  localparam int          CTRL_COLUMN   = 8;
  localparam int          SHIFT_COLUMN  = 6;
  localparam int          CTRL_ROW      = 0;
  localparam int          LSHIFT_ROW    = 0;
  localparam int          RSHIFT_ROW    = 6;
  localparam logic [7:0]  PREFIX_E0     = 8'he0;
  localparam logic [7:0]  BREAK_F0      = 8'hf0;
  localparam logic [7:0]  CTRL_MAKE     = 8'h14;
  localparam logic [7:0]  RSHIFT_MAKE   = 8'h11;
  localparam logic [7:0]  ALT_MAKE      = 8'h11;
  localparam logic [7:0]  LSHIFT_MAKE   = 8'h12;
  localparam int          SETTLE_CYCLES = 16;
  localparam int          STALL_LIMIT   = 3000;

  localparam logic [10:0] PLAIN_CODES [TABLE_SIZE] = '{
    11'h01e, 11'h02e, 11'h03e, 11'h055, 11'h00a, 11'h16c, 11'h000, 11'h000,
    11'h016, 11'h025, 11'h03d, 11'h045, 11'h083, 11'h17a, 11'h000, 11'h001,
    11'h076, 11'h01b, 11'h02b, 11'h033, 11'h05d, 11'h042, 11'h04c, 11'h003,
    11'h01c, 11'h023, 11'h034, 11'h03b, 11'h05a, 11'h04b, 11'h052, 11'h00b,
    11'h00d, 11'h01d, 11'h02d, 11'h035, 11'h05b, 11'h043, 11'h04d, 11'h446,
    11'h015, 11'h024, 11'h02c, 11'h03c, 11'h43e, 11'h044, 11'h054, 11'h00c,
    11'h000, 11'h021, 11'h032, 11'h049, 11'h461, 11'h000, 11'h000, 11'h004,
    11'h01a, 11'h02a, 11'h031, 11'h041, 11'h415, 11'h000, 11'h172, 11'h006,
    11'h000, 11'h022, 11'h029, 11'h03a, 11'h174, 11'h000, 11'h04a, 11'h005,
    11'h061, 11'h026, 11'h036, 11'h046, 11'h066, 11'h04e, 11'h000, 11'h000
  };

  localparam logic [10:0] SHIFTED_CODES [TABLE_SIZE] = '{
    11'h21e, 11'h22e, 11'h23e, 11'h255, 11'h20a, 11'h169, 11'h000, 11'h000,
    11'h216, 11'h225, 11'h23d, 11'h245, 11'h283, 11'h17d, 11'h000, 11'h201,
    11'h276, 11'h21b, 11'h22b, 11'h233, 11'h25d, 11'h242, 11'h24c, 11'h203,
    11'h21c, 11'h223, 11'h234, 11'h23b, 11'h05a, 11'h24b, 11'h252, 11'h20b,
    11'h00d, 11'h21d, 11'h22d, 11'h235, 11'h25b, 11'h243, 11'h24d, 11'h44e,
    11'h215, 11'h224, 11'h22c, 11'h23c, 11'h00e, 11'h244, 11'h254, 11'h20c,
    11'h000, 11'h221, 11'h232, 11'h249, 11'h45b, 11'h000, 11'h000, 11'h204,
    11'h21a, 11'h22a, 11'h231, 11'h241, 11'h000, 11'h000, 11'h175, 11'h206,
    11'h000, 11'h222, 11'h000, 11'h23a, 11'h16b, 11'h000, 11'h24a, 11'h205,
    11'h261, 11'h226, 11'h236, 11'h246, 11'h171, 11'h24e, 11'h000, 11'h000
  };

  logic         clk;
  logic         rst_n     = 1'b0;
  in_payload_t  in_data   = '0;
  logic         push      = 1'b0;
  logic         full;
  out_payload_t out_data;
  logic         empty;
  logic         pop       = 1'b0;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = mk2ps2_pkg::REG_TYPEMATIC_DELAY;
  logic [9:0]   cfg_data  = '0;

  // predictor state
  logic [9:0]   delay_cfg    = 10'd500;
  logic [8:0]   rate_cfg     = 9'd54;
  logic [7:0]   settle_cfg   = 8'd2;
  logic [7:0]   pass_key     = KEY_NONE;
  logic [2:0]   pass_mods    = '0;
  logic [2:0]   mods_latched = '0;
  logic [7:0]   cand_key     = KEY_NONE;
  logic [7:0]   down_key     = KEY_NONE;
  logic [10:0]  settle_ms    = '0;
  logic [10:0]  hold_ms      = '0;
  bit           auto_rep     = 1'b0;

  logic [7:0]   byte_run[$];
  out_payload_t expected_bytes[$];

  int mismatches   = 0;
  int samples_sent = 0;
  int pop_hold     = 0;
  bit in_idle_en   = 1'b1;
  bit out_idle_en  = 1'b1;

  matrix_key_to_ps2_encoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .push      (push),
    .full      (full),
    .out_data  (out_data),
    .empty     (empty),
    .pop       (pop),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [10:0] code_of_down_key();
    if (down_key >= 8'(TABLE_SIZE)) return 11'd0;
    return mods_latched[M_LSHIFT] ? SHIFTED_CODES[down_key] : PLAIN_CODES[down_key];
  endfunction

  task automatic add_make(input bit with_mods);
    logic [10:0] c;
    c = code_of_down_key();
    if (c != 11'd0) begin
      if (with_mods) begin
        if (mods_latched[M_CTRL]) byte_run.push_back(CTRL_MAKE);
        if (mods_latched[M_RSHIFT]) byte_run.push_back(RSHIFT_MAKE);
        if (c[HAS_SHIFT]) byte_run.push_back(LSHIFT_MAKE);
        if (c[HAS_ALTGR]) begin
          byte_run.push_back(PREFIX_E0);
          byte_run.push_back(ALT_MAKE);
        end
      end
      if (c[HAS_E0]) byte_run.push_back(PREFIX_E0);
      byte_run.push_back(c[7:0]);
    end
  endtask

  task automatic add_break();
    logic [10:0] c;
    c = code_of_down_key();
    if (c != 11'd0) begin
      if (c[HAS_E0]) byte_run.push_back(PREFIX_E0);
      byte_run.push_back(BREAK_F0);
      byte_run.push_back(c[7:0]);
      if (c[HAS_ALTGR]) begin
        byte_run.push_back(PREFIX_E0);
        byte_run.push_back(BREAK_F0);
        byte_run.push_back(ALT_MAKE);
      end
      if (c[HAS_SHIFT]) begin
        byte_run.push_back(BREAK_F0);
        byte_run.push_back(LSHIFT_MAKE);
      end
      // modifiers released in reverse order of the make run
      if (mods_latched[M_RSHIFT]) begin
        byte_run.push_back(BREAK_F0);
        byte_run.push_back(RSHIFT_MAKE);
      end
      if (mods_latched[M_CTRL]) begin
        byte_run.push_back(BREAK_F0);
        byte_run.push_back(CTRL_MAKE);
      end
    end
  endtask

  task automatic judge_key_pass();
    logic [10:0] lim;
    if (down_key == KEY_NONE) begin
      if (cand_key == KEY_NONE) begin
        cand_key     = pass_key;
        mods_latched = pass_mods;
        if (cand_key != KEY_NONE) settle_ms = '0;
      end else if (settle_ms > settle_cfg) begin
        mods_latched = pass_mods;
        if (pass_key == cand_key) begin
          down_key = pass_key;
          add_make(1'b1);
          hold_ms  = '0;
          auto_rep = 1'b0;
        end
        cand_key = KEY_NONE;
      end
    end else if (pass_key == KEY_NONE) begin
      add_break();
      down_key = KEY_NONE;
    end else begin
      lim = auto_rep ? 11'(rate_cfg) : 11'(delay_cfg);
      if (hold_ms > lim) begin
        add_make(1'b0);
        hold_ms  = '0;
        auto_rep = 1'b1;
      end
    end
  endtask

  task automatic encode_column_sample(input in_payload_t s);
    logic [7:0]   keys_only;
    int           b;
    out_payload_t entry;
    byte_run.delete();
    if (s.ms_tick) begin
      if (settle_ms < COUNT_MAX) settle_ms++;
      if (hold_ms < COUNT_MAX) hold_ms++;
    end
    if (int'(s.column) < NCOLS) begin
      if (s.column == 4'd0) begin
        pass_key  = KEY_NONE;
        pass_mods = '0;
      end
      keys_only = s.row_levels;
      if (int'(s.column) == CTRL_COLUMN) begin
        keys_only[CTRL_ROW] = 1'b1;
        if (!s.row_levels[CTRL_ROW]) pass_mods[M_CTRL] = 1'b1;
      end
      if (int'(s.column) == SHIFT_COLUMN) begin
        keys_only[LSHIFT_ROW] = 1'b1;
        keys_only[RSHIFT_ROW] = 1'b1;
        if (!s.row_levels[LSHIFT_ROW]) pass_mods[M_LSHIFT] = 1'b1;
        if (!s.row_levels[RSHIFT_ROW]) pass_mods[M_RSHIFT] = 1'b1;
      end
      if (pass_key == KEY_NONE && keys_only != 8'hff) begin
        b = 0;
        while (keys_only[b]) b++;
        pass_key = {1'b0, s.column, 3'(b)};
      end
      if (int'(s.column) == NCOLS - 1) judge_key_pass();
    end
    foreach (byte_run[i]) begin
      entry.ps2_byte  = byte_run[i];
      entry.last_byte = (i == byte_run.size() - 1);
      expected_bytes.push_back(entry);
    end
  endtask

  // ---------------------------------------------------------------- drivers

  function automatic in_payload_t column_item(input int col, input logic [7:0] row,
                                              input bit tick);
    in_payload_t it;
    it.column     = 4'(col);
    it.row_levels = row;
    it.ms_tick    = tick;
    return it;
  endfunction

  function automatic bit is_modifier_spot(input int k);
    return k == SHIFT_COLUMN * 8 + LSHIFT_ROW || k == SHIFT_COLUMN * 8 + RSHIFT_ROW ||
           k == CTRL_COLUMN * 8 + CTRL_ROW;
  endfunction

  function automatic logic [7:0] pick_key();
    int k;
    do k = $urandom_range(0, TABLE_SIZE - 1); while (is_modifier_spot(k));
    return 8'(k);
  endfunction

  task automatic send_item(input in_payload_t it);
    int gap;
    gap = (in_idle_en && $urandom_range(0, 4) == 0) ? $urandom_range(1, 15) : 0;
    @(negedge clk);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push    <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    if (int'(it.column) < NCOLS) samples_sent++;
    encode_column_sample(it);
  endtask

  // ignored columns still carry the tick, a cheap way to advance the timers
  task automatic pump_ticks(input int n);
    repeat (n) send_item(column_item($urandom_range(NCOLS, 15), 8'($urandom), 1'b1));
  endtask

  // one scan pass; short passes only visit column 0, columns with a closed
  // contact, and the last column
  task automatic scan_pass(input logic [7:0] key, input logic [2:0] mods,
                           input bit every_column, input int tick_pct);
    logic [7:0] rows [NCOLS];
    int         mid[$];
    int         stray;
    for (int c = 0; c < NCOLS; c++) rows[c] = 8'hff;
    if (key < 8'(TABLE_SIZE)) rows[key[6:3]][key[2:0]] = 1'b0;
    if (mods[M_CTRL]) rows[CTRL_COLUMN][CTRL_ROW] = 1'b0;
    if (mods[M_LSHIFT]) rows[SHIFT_COLUMN][LSHIFT_ROW] = 1'b0;
    if (mods[M_RSHIFT]) rows[SHIFT_COLUMN][RSHIFT_ROW] = 1'b0;
    // a second key that loses to the first one unless the middle columns run reversed
    stray = $urandom_range(0, TABLE_SIZE - 1);
    if ($urandom_range(0, 3) == 0 && stray > int'(key) && !is_modifier_spot(stray))
      rows[stray / 8][stray % 8] = 1'b0;
    for (int c = 1; c < NCOLS - 1; c++)
      if (every_column || rows[c] != 8'hff) mid.push_back(c);
    if ($urandom_range(0, 5) == 0) mid.reverse();
    send_item(column_item(0, rows[0], $urandom_range(0, 99) < tick_pct));
    foreach (mid[i])
      send_item(column_item(mid[i], rows[mid[i]], $urandom_range(0, 99) < tick_pct));
    send_item(column_item(NCOLS - 1, rows[NCOLS - 1], $urandom_range(0, 99) < tick_pct));
  endtask

  // input goes quiet until every expected byte has been taken
  task automatic settle_block();
    @(negedge clk);
    push <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [9:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      mk2ps2_pkg::REG_TYPEMATIC_DELAY:  delay_cfg  = value;
      mk2ps2_pkg::REG_TYPEMATIC_REPEAT: rate_cfg   = value[8:0];
      mk2ps2_pkg::REG_DEBOUNCE:         settle_cfg = value[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_timing(input int delay_ms, input int rate_ms, input int settle);
    settle_block();
    write_reg(mk2ps2_pkg::REG_TYPEMATIC_DELAY, 10'(delay_ms));
    write_reg(mk2ps2_pkg::REG_TYPEMATIC_REPEAT, 10'(rate_ms));
    write_reg(mk2ps2_pkg::REG_DEBOUNCE, 10'(settle));
  endtask

  // ---------------------------------------------------------------- tests

  // reset timing: 2 ms debounce, first repeat only after more than 500 ms
  task automatic test_reset_timing();
    scan_pass(8'd5, 3'b000, 1'b0, 0);
    pump_ticks(3);
    scan_pass(8'd5, 3'b000, 1'b0, 0);
    pump_ticks(500);
    scan_pass(8'd5, 3'b000, 1'b0, 0);
    pump_ticks(1);
    scan_pass(8'd5, 3'b000, 1'b0, 0);
    scan_pass(KEY_NONE, 3'b000, 1'b0, 0);
  endtask

  // all modifiers on an AltGr key; mods change while held, break keeps originals
  task automatic test_modifier_wraps();
    program_timing(0, 0, 0);
    scan_pass(8'd52, 3'b111, 1'b0, 100);
    scan_pass(8'd52, 3'b111, 1'b0, 100);
    scan_pass(8'd52, 3'b001, 1'b0, 100);
    scan_pass(KEY_NONE, 3'b000, 1'b0, 100);
  endtask

  // key without a code is tracked as pressed but sends nothing
  task automatic test_zero_code();
    scan_pass(8'd6, 3'b000, 1'b0, 100);
    scan_pass(8'd6, 3'b000, 1'b0, 100);
    scan_pass(8'd6, 3'b010, 1'b0, 100);
    scan_pass(KEY_NONE, 3'b000, 1'b0, 100);
  endtask

  task automatic test_odd_columns();
    send_item(column_item(13, 8'h00, 1'b1));
    send_item(column_item(NCOLS - 1, ~8'h04, 1'b0));
    send_item(column_item(15, 8'h00, 1'b1));
    send_item(column_item(NCOLS - 1, ~8'h04, 1'b0));
    send_item(column_item(5, 8'hfe, 1'b1));
    send_item(column_item(10, 8'h5a, 1'b0));
    send_item(column_item(NCOLS - 1, 8'hff, 1'b0));
    send_item(column_item(0, 8'hff, 1'b0));
    send_item(column_item(NCOLS - 1, 8'hff, 1'b0));
    // rescan sees a different key: candidate dropped
    send_item(column_item(0, ~8'h01, 1'b1));
    send_item(column_item(NCOLS - 1, 8'hff, 1'b0));
    send_item(column_item(0, 8'hff, 1'b1));
    send_item(column_item(3, ~8'h02, 1'b0));
    send_item(column_item(NCOLS - 1, 8'hff, 1'b0));
    scan_pass(KEY_NONE, 3'b000, 1'b0, 0);
  endtask

  // top register values and saturating timers
  task automatic test_timer_limits();
    program_timing(1023, 511, 255);
    scan_pass(8'd76, 3'b000, 1'b0, 0);
    pump_ticks(255);
    scan_pass(8'd76, 3'b000, 1'b0, 0);
    pump_ticks(1);
    scan_pass(8'd76, 3'b000, 1'b0, 0);
    pump_ticks(2100);
    scan_pass(8'd76, 3'b000, 1'b0, 0);
    pump_ticks(511);
    scan_pass(8'd76, 3'b000, 1'b0, 0);
    pump_ticks(1);
    scan_pass(8'd76, 3'b000, 1'b0, 0);
    scan_pass(KEY_NONE, 3'b000, 1'b0, 0);
  endtask

  // receiver holds off while repeats pile up, then the sender waits for a drain
  task automatic test_backpressure();
    program_timing(0, 0, 0);
    pop_hold = 300;
    repeat (14) scan_pass(8'd5, 3'b000, 1'b0, 100);
    settle_block();
    scan_pass(8'd5, 3'b000, 1'b0, 100);
    scan_pass(KEY_NONE, 3'b000, 1'b0, 100);
  endtask

  task automatic test_random_typing(input int n_samples, input bit quiet);
    int          stop_at;
    int          sel;
    logic [7:0]  key;
    logic [2:0]  mods;
    bit          every_column;
    program_timing($urandom_range(0, 12), $urandom_range(0, 6), $urandom_range(0, 3));
    in_idle_en  = !quiet;
    out_idle_en = !quiet;
    stop_at     = samples_sent + n_samples;
    while (samples_sent < stop_at) begin
      sel          = $urandom_range(0, 9);
      key          = pick_key();
      mods         = 3'($urandom_range(0, 7));
      every_column = ($urandom_range(0, 4) == 0);
      if (sel < 7) begin
        scan_pass(key, mods, every_column, 50);
        repeat ($urandom_range(1, 5))
          scan_pass(key, ($urandom_range(0, 5) == 0) ? 3'($urandom_range(0, 7)) : mods,
                    every_column, 60);
        repeat ($urandom_range(1, 2))
          scan_pass(KEY_NONE, 3'($urandom_range(0, 7)), every_column, 50);
      end else if (sel < 9) begin
        repeat ($urandom_range(1, 4))
          send_item(column_item($urandom_range(0, 15), 8'($urandom), $urandom_range(0, 1)));
      end else begin
        // bouncing contact: detection and rescan disagree
        scan_pass(key, mods, every_column, 50);
        scan_pass(pick_key(), mods, every_column, 50);
      end
    end
  endtask

  // ---------------------------------------------------------------- checking

  initial begin : pop_driver
    forever begin
      @(negedge clk);
      if (pop_hold > 0) begin
        pop <= 1'b0;
        pop_hold--;
      end else if (out_idle_en && $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        pop_hold = $urandom_range(0, 14);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin : byte_checker
    out_payload_t got;
    out_payload_t want;
    bit           took;
    forever begin
      @(posedge clk);
      took = rst_n && pop && !empty;
      got  = out_data;
      if (took) begin
        // let the sender log its prediction for this edge first
        #1;
        if (expected_bytes.size() == 0) begin
          $display("%0t: byte with none expected: expected none, actual %h last %b",
                   $time, got.ps2_byte, got.last_byte);
          mismatches++;
        end else begin
          want = expected_bytes.pop_front();
          if (got.ps2_byte !== want.ps2_byte) begin
            $display("%0t: ps2_byte mismatch: expected %h, actual %h",
                     $time, want.ps2_byte, got.ps2_byte);
            mismatches++;
          end
          if (got.last_byte !== want.last_byte) begin
            $display("%0t: last_byte mismatch: expected %b, actual %b",
                     $time, want.last_byte, got.last_byte);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t: no transaction for %0d cycles, %0d bytes outstanding",
             $time, STALL_LIMIT, expected_bytes.size());
    $display("TB_ERROR");
    $finish;
  end

  initial begin : run_tests
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_timing();
    test_modifier_wraps();
    test_zero_code();
    test_odd_columns();
    test_timer_limits();
    test_backpressure();
    test_random_typing(60, 1'b0);
    test_random_typing(60, 1'b0);
    test_random_typing(35, 1'b1);
    settle_block();
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/mk2ps2_pkg.sv
hw/rtl/mk2ps2_front.sv
hw/rtl/mk2ps2_cmdq.sv
hw/rtl/mk2ps2_back.sv
hw/rtl/matrix_key_to_ps2_encoder.sv
tb/sv/matrix_key_to_ps2_encoder_tb.sv
